// ===== hdl/lj_pkg.sv =====
`default_nettype none

package lj_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned ENERGY_W = 64;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CFG_W-1:0] ATOM_COUNT_RESET = 7'd3;
  localparam logic [CFG_W-1:0] ATOM_COUNT_MIN   = 7'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COINCIDENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;

  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ENERGY_W-1:0] ACC_LIMIT  = 64'sh1FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] coordinate;
    logic                      last;
  } coord_in_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic [STATUS_W-1:0]        status;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/lj_front.sv =====
`default_nettype none

module lj_front #(
  parameter int unsigned MAX_ATOMS = 64,
  localparam int unsigned DEPTH = 3 * MAX_ATOMS - 6,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned LW = $clog2(DEPTH + 1),
  localparam int unsigned NW = $clog2(MAX_ATOMS + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire lj_pkg::coord_in_t                 in_data_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lj_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic                              hold_i,
  input  wire logic                              full_i,
  output logic                                   push_o,
  output logic [NW-1:0]                          job_o,
  output logic                                   wr_en_o,
  output logic [AW-1:0]                          wr_addr_o,
  output logic signed [lj_pkg::COORD_W-1:0]      wr_data_o
);

  logic [lj_pkg::CFG_W-1:0] atom_count_q;
  logic [LW-1:0]            load_cnt_q;
  logic                     accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !hold_i && !full_i;
  assign accept      = in_valid_i && in_ready_o;

  assign wr_en_o   = accept && (load_cnt_q < LW'(DEPTH));
  assign wr_addr_o = load_cnt_q[AW-1:0];
  assign wr_data_o = in_data_i.coordinate;
  assign push_o    = accept && in_data_i.last;

  always_comb begin
    priority if (32'(atom_count_q) > MAX_ATOMS) begin
      job_o = NW'(MAX_ATOMS);
    end else if (atom_count_q < lj_pkg::ATOM_COUNT_MIN) begin
      job_o = NW'(lj_pkg::ATOM_COUNT_MIN);
    end else begin
      job_o = NW'(atom_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= lj_pkg::ATOM_COUNT_RESET;
      load_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        atom_count_q <= cfg_data_i;
      end
      if (accept) begin
        if (in_data_i.last) begin
          load_cnt_q <= '0;
        end else if (wr_en_o) begin
          load_cnt_q <= load_cnt_q + LW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lj_jobq.sv =====
`default_nettype none

module lj_jobq #(
  parameter int unsigned W = 7
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] din_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      dout_o,
  output logic              empty_o,
  output logic              full_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push;
  logic         do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign dout_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lj_eng.sv =====
`default_nettype none

module lj_eng #(
  parameter int unsigned MAX_ATOMS = 64,
  localparam int unsigned DEPTH = 3 * MAX_ATOMS - 6,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned NW = $clog2(MAX_ATOMS + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  input  wire logic [NW-1:0]                 job_i,
  output logic                               job_pop_o,
  output logic                               busy_o,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic signed [lj_pkg::COORD_W-1:0] wr_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lj_pkg::result_t                    out_data_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDI  = 3'd1;
  localparam logic [2:0] ST_RDJ  = 3'd2;
  localparam logic [2:0] ST_CLS  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_NEXT = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [4:0] RD_LAST  = 5'd3;
  localparam logic [4:0] DIV_LAST = 5'd31;
  localparam logic [4:0] MUL_LAST = 5'd10;
  localparam logic [49:0] D_MIN    = 50'h1_0000_0000;
  localparam logic [49:0] REM_INIT = 50'h8000_0000;
  localparam logic [31:0] U_MAX    = 32'h8000_0000;

  logic [2:0]  state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [NW-1:0] n_q, i_q, j_q;
  logic signed [lj_pkg::COORD_W-1:0] pi_q [3];
  logic [49:0] d_q;
  logic [49:0] rem_q;
  logic [31:0] u_q;
  logic [63:0] u2_q;
  logic [63:0] mp_q;
  logic [96:0] p_q;
  logic [48:0] s_q;
  logic signed [63:0] acc_q;
  logic        co_q, ov_q;
  lj_pkg::result_t res_q;

  logic signed [lj_pkg::COORD_W-1:0] store_q [DEPTH];
  logic signed [lj_pkg::COORD_W-1:0] rd_q;
  logic        rdz_q;

  logic [NW-1:0] rd_atom;
  logic [1:0]    rd_axis;
  logic [AW:0]   lin;
  logic [AW-1:0] rd_addr;
  logic          rd_zero;
  logic signed [lj_pkg::COORD_W-1:0] rdv;
  logic [1:0]    cap_idx;
  logic signed [24:0] diff;
  logic signed [49:0] sq;
  logic [50:0]   trial;
  logic          ge;
  logic [49:0]   rem_d;
  logic [31:0]   mul_a, mul_b;
  logic [61:0]   q_val;
  logic signed [63:0] acc_sum;

  // position lookup: atoms 0..2 are partly pinned to zero
  assign rd_atom = (state_q == ST_RDI) ? i_q : j_q;
  assign rd_axis = step_q[1:0];
  assign lin = (AW+1)'({rd_atom, 1'b0}) + (AW+1)'(rd_atom) + (AW+1)'(rd_axis) - (AW+1)'(6);

  always_comb begin
    rd_zero = (rd_atom == NW'(0)) || ((rd_atom == NW'(1)) && (rd_axis != 2'd2))
              || ((rd_atom == NW'(2)) && (rd_axis == 2'd0));
    priority if (rd_atom == NW'(1)) begin
      rd_addr = '0;
    end else if (rd_atom == NW'(2)) begin
      rd_addr = AW'(rd_axis);
    end else begin
      rd_addr = lin[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
    rd_q  <= store_q[rd_addr];
    rdz_q <= rd_zero;
  end

  assign rdv     = rdz_q ? '0 : rd_q;
  assign cap_idx = step_q[1:0] - 2'd1;
  assign diff    = 25'(pi_q[cap_idx]) - 25'(rdv);
  assign sq      = diff * diff;

  assign trial = {rem_q, 1'b0};
  assign ge    = (trial >= {1'b0, d_q});
  assign rem_d = ge ? 50'(trial - {1'b0, d_q}) : trial[49:0];

  always_comb begin
    unique case (step_q)
      5'd0:    begin mul_a = u_q;          mul_b = u_q;                end
      5'd2:    begin mul_a = u2_q[31:0];   mul_b = u_q;                end
      5'd3:    begin mul_a = u2_q[63:32];  mul_b = u_q;                end
      5'd6:    begin mul_a = s_q[31:0];    mul_b = s_q[31:0];          end
      5'd7:    begin mul_a = s_q[31:0];    mul_b = {15'd0, s_q[48:32]}; end
      5'd8:    begin mul_a = {15'd0, s_q[48:32]}; mul_b = {15'd0, s_q[48:32]}; end
      default: begin mul_a = '0;           mul_b = '0;                 end
    endcase
  end

  assign q_val   = p_q[85:24];
  assign acc_sum = acc_q + signed'(64'(q_val)) - signed'(64'(s_q));

  always_comb begin
    state_d = state_q;
    step_d  = step_q + 5'd1;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (job_valid_i) begin
          state_d = ST_RDI;
        end
      end
      ST_RDI: begin
        if (step_q == RD_LAST) begin
          state_d = ST_RDJ;
          step_d  = '0;
        end
      end
      ST_RDJ: begin
        if (step_q == RD_LAST) begin
          state_d = ST_CLS;
          step_d  = '0;
        end
      end
      ST_CLS: begin
        step_d = '0;
        if ((d_q == '0) || ov_q || (d_q < D_MIN)) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == DIV_LAST) begin
          state_d = ST_MUL;
          step_d  = '0;
        end
      end
      ST_MUL: begin
        if (step_q == MUL_LAST) begin
          state_d = ST_NEXT;
          step_d  = '0;
        end
      end
      ST_NEXT: begin
        step_d = '0;
        priority if (j_q + NW'(1) < n_q) begin
          state_d = ST_RDJ;
        end else if (i_q + NW'(2) < n_q) begin
          state_d = ST_RDI;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        step_d = '0;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mp_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          n_q   <= job_i;
          i_q   <= '0;
          j_q   <= NW'(1);
          co_q  <= 1'b0;
          ov_q  <= 1'b0;
          acc_q <= '0;
        end
      end
      ST_RDI: begin
        if (step_q != 5'd0) begin
          pi_q[cap_idx] <= rdv;
        end
      end
      ST_RDJ: begin
        if (step_q == 5'd0) begin
          d_q <= '0;
        end else begin
          d_q <= d_q + 50'(unsigned'(sq));
        end
      end
      ST_CLS: begin
        rem_q <= REM_INIT;
        u_q   <= '0;
        if (d_q == '0) begin
          co_q <= 1'b1;
        end else if (!ov_q && (d_q < D_MIN)) begin
          ov_q <= 1'b1;
        end
      end
      ST_DIV: begin
        rem_q <= rem_d;
        u_q   <= {u_q[30:0], ge};
      end
      ST_MUL: begin
        unique case (step_q)
          5'd1:  u2_q <= mp_q;
          5'd3:  p_q  <= 97'(mp_q);
          5'd4:  p_q  <= p_q + (97'(mp_q) << 32);
          5'd5:  s_q  <= p_q[93:45];
          5'd7:  p_q  <= 97'(mp_q);
          5'd8:  p_q  <= p_q + (97'(mp_q) << 33);
          5'd9:  p_q  <= p_q + (97'(mp_q) << 64);
          5'd10: begin
            if (|p_q[96:86]) begin
              ov_q <= 1'b1;
            end else begin
              acc_q <= acc_sum;
              if (acc_sum > lj_pkg::ACC_LIMIT) begin
                ov_q <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_NEXT: begin
        if (j_q + NW'(1) < n_q) begin
          j_q <= j_q + NW'(1);
        end else begin
          i_q <= i_q + NW'(1);
          j_q <= i_q + NW'(2);
        end
        priority if (co_q) begin
          res_q.energy <= lj_pkg::ENERGY_MAX;
          res_q.status <= lj_pkg::ST_COINCIDENT;
        end else if (ov_q) begin
          res_q.energy <= lj_pkg::ENERGY_MAX;
          res_q.status <= lj_pkg::ST_OVERFLOW;
        end else begin
          res_q.energy <= {acc_q[61:0], 2'b00};
          res_q.status <= lj_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign job_pop_o   = (state_q == ST_IDLE) && job_valid_i;
  assign busy_o      = (state_q != ST_IDLE) && (state_q != ST_OUT);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o  = res_q;

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < d_q))
    else $error("divider remainder not below divisor");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDJ) |-> ((j_q > i_q) && (j_q < n_q)))
    else $error("pair index out of order");

  a_recip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (u_q <= U_MAX))
    else $error("reciprocal out of range");

endmodule

`default_nettype wire

// ===== hdl/lennard_jones_cluster_energy.sv =====
// Lennard-Jones cluster energy. Coordinates (signed Q4.20) are loaded one per
// beat into a coordinate store; a beat with last set queues an evaluation that
// walks all atom pairs and returns one result beat: energy (signed Q40.24,
// saturated) and status (0 ok, 1 coincident atoms, 2 overflow). Non-last
// beats are accepted back to back unless held off. Each pair takes 3 store
// reads, one classify step, a one-bit-per-cycle divider for 1/r^2 and 11
// steps on a shared 32x32 multiplier, plus reads of the first atom when it
// changes; pairs that coincide, come too close or follow an overflow skip the
// divider and multiplier. New coordinates are held off while an evaluation
// runs, but are taken while a result waits. atom_count is written through the
// cfg channel and clamped to 3..MAX_ATOMS.
`default_nettype none

module lennard_jones_cluster_energy #(
  parameter int unsigned MAX_ATOMS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire lj_pkg::coord_in_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output lj_pkg::result_t                out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [lj_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned DEPTH = 3 * MAX_ATOMS - 6;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(MAX_ATOMS + 1);

  logic          push;
  logic [NW-1:0] job_in;
  logic [NW-1:0] job_out;
  logic          q_empty;
  logic          q_full;
  logic          pop;
  logic          eng_busy;
  logic          hold;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [lj_pkg::COORD_W-1:0] wr_data;

  assign hold = eng_busy || !q_empty;

  lj_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .hold_i      (hold),
    .full_i      (q_full),
    .push_o      (push),
    .job_o       (job_in),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  lj_jobq #(.W(NW)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (job_in),
    .pop_i   (pop),
    .dout_o  (job_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lj_eng #(.MAX_ATOMS(MAX_ATOMS)) u_eng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .busy_o      (eng_busy),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
